@@ sv/dss_pkg.sv @@
// Shared types and constants for the delimiter stream splitter.
package dss_pkg;

  localparam int MAX_DELIM_DEFAULT = 8;
  localparam int LANES             = 8;
  localparam int FILL_W            = 4;
  localparam int LEN_W             = 32;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic CFG_DELIM_LENGTH = 1'b0;
  localparam logic CFG_DELIM_BYTES  = 1'b1;

  localparam logic [3:0]  DELIM_LENGTH_RESET = 4'd1;
  localparam logic [63:0] DELIM_BYTES_RESET  = 64'd44;

  typedef struct packed {
    logic                       first_valid;
    logic                       first_end;
    logic [7:0]                 first_byte;
    logic [LEN_W-1:0]           first_len;
    logic                       eos;
    logic [FILL_W-1:0]          flush_cnt;
    logic [LANES-1:0][7:0]      flush_win;
    logic [LEN_W-1:0]           final_len;
  } entry_t;

endpackage

@@ sv/dss_front.sv @@
// Front end: window, delimiter compare, part length and configuration registers.
module dss_front #(
  parameter int MAX_DELIM = dss_pkg::MAX_DELIM_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic                accept,
  input  logic [7:0]          source_byte,
  input  logic                has_byte,
  input  logic                end_of_source,
  output logic                q_push,
  output dss_pkg::entry_t     q_data
);

  localparam int FW    = dss_pkg::FILL_W;
  localparam int LW    = dss_pkg::LEN_W;
  localparam int IDX_W = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;
  localparam logic [FW-1:0] MAX_FILL = FW'(MAX_DELIM);

  logic [7:0]    win [MAX_DELIM];
  logic [FW-1:0] fill;
  logic [LW-1:0] cur_len;
  logic [3:0]    delim_length;
  logic [63:0]   delim_bytes;

  logic [7:0]    win1 [MAX_DELIM];
  logic [7:0]    win_next [MAX_DELIM];
  logic [FW-1:0] fill1;
  logic [FW-1:0] fill2;
  logic [FW-1:0] fill_next;
  logic [LW-1:0] len2;
  logic [LW-1:0] cur_len_next;
  logic [3:0]    eff_len;
  logic          matched;
  logic [LW:0]   final_sum;

  always_comb begin
    eff_len = (delim_length > 4'(MAX_DELIM)) ? 4'(MAX_DELIM) : delim_length;

    win1  = win;
    fill1 = fill;
    if (fill < MAX_FILL) begin
      win1[fill[IDX_W-1:0]] = source_byte;
      fill1 = fill + 1'b1;
    end

    matched = 1'b1;
    for (int i = 0; i < MAX_DELIM; i++) begin
      if ((4'(i) < eff_len) && (win1[i] != delim_bytes[8*i +: 8])) begin
        matched = 1'b0;
      end
    end

    q_data       = '0;
    win_next     = win;
    fill2        = fill;
    len2         = cur_len;

    if (has_byte) begin
      win_next = win1;
      fill2    = fill1;
      if ((4'(fill1) > eff_len) ||
          ((4'(fill1) == eff_len) && (eff_len != 4'd0) && !matched)) begin
        q_data.first_valid = 1'b1;
        q_data.first_byte  = win1[0];
        for (int i = 0; i < MAX_DELIM - 1; i++) begin
          win_next[i] = win1[i+1];
        end
        win_next[MAX_DELIM-1] = 8'd0;
        fill2 = fill1 - 1'b1;
        len2  = (cur_len == {LW{1'b1}}) ? cur_len : cur_len + 1'b1;
      end else if ((4'(fill1) == eff_len) && (eff_len != 4'd0)) begin
        q_data.first_valid = 1'b1;
        q_data.first_end   = 1'b1;
        q_data.first_len   = cur_len;
        for (int i = 0; i < MAX_DELIM; i++) begin
          win_next[i] = 8'd0;
        end
        fill2 = '0;
        len2  = '0;
      end
    end

    final_sum    = {1'b0, len2} + (LW+1)'(fill2);
    fill_next    = fill2;
    cur_len_next = len2;

    if (end_of_source) begin
      q_data.eos       = 1'b1;
      q_data.flush_cnt = fill2;
      for (int i = 0; i < MAX_DELIM; i++) begin
        q_data.flush_win[i] = win_next[i];
      end
      q_data.final_len = final_sum[LW] ? {LW{1'b1}} : final_sum[LW-1:0];
      for (int i = 0; i < MAX_DELIM; i++) begin
        win_next[i] = 8'd0;
      end
      fill_next    = '0;
      cur_len_next = '0;
    end

    q_push = accept && (q_data.first_valid || end_of_source);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      cur_len      <= '0;
      delim_length <= dss_pkg::DELIM_LENGTH_RESET;
      delim_bytes  <= dss_pkg::DELIM_BYTES_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dss_pkg::CFG_DELIM_LENGTH: delim_length <= cfg_data[3:0];
          dss_pkg::CFG_DELIM_BYTES:  delim_bytes  <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        fill    <= fill_next;
        cur_len <= cur_len_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win <= win_next;
    end
  end

endmodule

@@ sv/dss_queue.sv @@
// Short queue of classified items between the front and back ends.
module dss_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  dss_pkg::entry_t   wr_data,
  input  logic              rd_en,
  output dss_pkg::entry_t   rd_data,
  output logic              full,
  output logic              not_empty
);

  localparam int DEPTH = dss_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dss_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ sv/dss_back.sv @@
// Back end: expands queued items into results and holds the output register.
module dss_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  dss_pkg::entry_t   q_head,
  output logic              q_pop,
  output logic [7:0]        part_byte,
  output logic              is_part_end,
  output logic [31:0]       part_length,
  output logic              is_final_part,
  output logic              run_last,
  output logic              empty,
  input  logic              pop
);

  localparam int FW = dss_pkg::FILL_W;
  localparam int LI = $clog2(dss_pkg::LANES);

  logic          out_valid;
  logic          first_done;
  logic [FW-1:0] flush_idx;
  logic          take;
  logic          load;

  logic [7:0]    r_byte;
  logic          r_end;
  logic [31:0]   r_len;
  logic          r_fin;
  logic          r_last;
  logic          r_first;
  logic          r_flush;

  assign empty = !out_valid;
  assign take  = !out_valid || pop;
  assign load  = take && q_valid;
  assign q_pop = load && r_last;

  always_comb begin
    r_byte  = 8'd0;
    r_end   = 1'b0;
    r_len   = '0;
    r_fin   = 1'b0;
    r_last  = 1'b0;
    r_first = 1'b0;
    r_flush = 1'b0;
    if (q_head.first_valid && !first_done) begin
      r_first = 1'b1;
      r_end   = q_head.first_end;
      r_byte  = q_head.first_end ? 8'd0 : q_head.first_byte;
      r_len   = q_head.first_end ? q_head.first_len : '0;
      r_last  = !q_head.eos;
    end else if (flush_idx < q_head.flush_cnt) begin
      r_flush = 1'b1;
      r_byte  = q_head.flush_win[flush_idx[LI-1:0]];
    end else begin
      r_end  = 1'b1;
      r_len  = q_head.final_len;
      r_fin  = 1'b1;
      r_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      first_done <= 1'b0;
      flush_idx  <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      if (r_last) begin
        first_done <= 1'b0;
        flush_idx  <= '0;
      end else begin
        if (r_first) begin
          first_done <= 1'b1;
        end
        if (r_flush) begin
          flush_idx <= flush_idx + 1'b1;
        end
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      part_byte     <= r_byte;
      is_part_end   <= r_end;
      part_length   <= r_len;
      is_final_part <= r_fin;
      run_last      <= r_last;
    end
  end

endmodule

@@ sv/delimiter_stream_splitter.sv @@
// Top level of the delimiter stream splitter: front end, item queue and back end.
// A result reaches the output ports through the item queue and the output register.
// Throughput: one item per cycle while the queue is not full, results are popped
// and each gives at most one result; an end of source item gives its leftover
// window bytes plus one as results, one per cycle while popped (up to 9 per item).
// Reset (synchronous): empties window, queue and output; delimiter set to one comma.
module delimiter_stream_splitter #(
  parameter int MAX_DELIM = dss_pkg::MAX_DELIM_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  source_byte,
  input  logic        has_byte,
  input  logic        end_of_source,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  part_byte,
  output logic        is_part_end,
  output logic [31:0] part_length,
  output logic        is_final_part,
  output logic        run_last
);

  logic            accept;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  dss_pkg::entry_t q_wr;
  dss_pkg::entry_t q_head;

  assign accept = push && !full;

  dss_front #(
    .MAX_DELIM(MAX_DELIM)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .source_byte  (source_byte),
    .has_byte     (has_byte),
    .end_of_source(end_of_source),
    .q_push       (q_push),
    .q_data       (q_wr)
  );

  dss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_data  (q_wr),
    .rd_en    (q_pop),
    .rd_data  (q_head),
    .full     (full),
    .not_empty(q_valid)
  );

  dss_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .part_byte    (part_byte),
    .is_part_end  (is_part_end),
    .part_length  (part_length),
    .is_final_part(is_final_part),
    .run_last     (run_last),
    .empty        (empty),
    .pop          (pop)
  );

endmodule

@@ bench/delimiter_stream_splitter_tb.sv @@
// Self-checking testbench for the delimiter stream splitter: directed table, then random sources.
`timescale 1ns / 100ps

module delimiter_stream_splitter_tb;

  localparam int SPAN_MAX = dss_pkg::MAX_DELIM_DEFAULT;

  typedef struct packed {
    logic [7:0]  part_byte;
    logic        is_part_end;
    logic [31:0] part_length;
    logic        is_final_part;
    logic        run_last;
  } split_result_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_SET_LENGTH, ROW_SET_BYTES} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [63:0] value;
    logic        has;
    logic        eos;
    logic [7:0]  t_byte;
    logic        t_end;
    logic [31:0] t_len;
    logic        t_fin;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [63:0] cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  source_byte = '0;
  logic        has_byte = 1'b0;
  logic        end_of_source = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  part_byte;
  logic        is_part_end;
  logic [31:0] part_length;
  logic        is_final_part;
  logic        run_last;

  logic [7:0]    tail_bytes [SPAN_MAX];
  int unsigned   tail_fill = 0;
  logic [31:0]   open_length = '0;
  logic [3:0]    delim_len_q = dss_pkg::DELIM_LENGTH_RESET;
  logic [63:0]   delim_bytes_q = dss_pkg::DELIM_BYTES_RESET;

  split_result_t expected_parts [$];
  split_result_t step_results [$];
  int unsigned   fail_count = 0;
  int unsigned   source_items = 0;
  int unsigned   choke_cycles = 0;
  bit            steady = 1'b0;

  stim_row_t directed_rows [33] = '{
    '{ROW_TYPED,      64'h0,  1'b0, 1'b1, 8'h00, 1'b1, 32'd0, 1'b1},
    '{ROW_ITEM,       64'h0,  1'b0, 1'b0, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_TYPED,      64'h61, 1'b1, 1'b0, 8'h61, 1'b0, 32'd0, 1'b0},
    '{ROW_TYPED,      64'h2C, 1'b1, 1'b0, 8'h00, 1'b1, 32'd1, 1'b0},
    '{ROW_ITEM,       64'h00, 1'b1, 1'b1, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_TYPED,      64'hFF, 1'b1, 1'b0, 8'hFF, 1'b0, 32'd0, 1'b0},
    '{ROW_TYPED,      64'h0,  1'b0, 1'b1, 8'h00, 1'b1, 32'd1, 1'b1},
    '{ROW_ITEM,       64'h2C, 1'b1, 1'b1, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_SET_LENGTH, 64'd0,  1'b0, 1'b0, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_TYPED,      64'hA5, 1'b1, 1'b0, 8'hA5, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM,       64'h5A, 1'b1, 1'b1, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_SET_BYTES,  64'h636261, 1'b0, 1'b0, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_SET_LENGTH, 64'd3,  1'b0, 1'b0, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM,       64'h61, 1'b1, 1'b0, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM,       64'h62, 1'b1, 1'b0, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_TYPED,      64'h63, 1'b1, 1'b0, 8'h00, 1'b1, 32'd0, 1'b0},
    '{ROW_ITEM,       64'h78, 1'b1, 1'b0, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM,       64'h61, 1'b1, 1'b1, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_SET_BYTES,  '1,     1'b0, 1'b0, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_SET_LENGTH, 64'd15, 1'b0, 1'b0, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM,       64'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM,       64'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM,       64'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM,       64'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM,       64'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM,       64'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM,       64'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_TYPED,      64'hFF, 1'b1, 1'b0, 8'h00, 1'b1, 32'd0, 1'b0},
    '{ROW_TYPED,      64'h0,  1'b0, 1'b1, 8'h00, 1'b1, 32'd0, 1'b1},
    '{ROW_SET_BYTES,  64'h0,  1'b0, 1'b0, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_SET_LENGTH, 64'd2,  1'b0, 1'b0, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM,       64'h00, 1'b1, 1'b0, 8'h00, 1'b0, 32'd0, 1'b0},
    '{ROW_ITEM,       64'h00, 1'b1, 1'b1, 8'h00, 1'b0, 32'd0, 1'b0}
  };

  delimiter_stream_splitter i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .source_byte   (source_byte),
    .has_byte      (has_byte),
    .end_of_source (end_of_source),
    .empty         (empty),
    .pop           (pop),
    .part_byte     (part_byte),
    .is_part_end   (is_part_end),
    .part_length   (part_length),
    .is_final_part (is_final_part),
    .run_last      (run_last)
  );

  always #6 clk = ~clk;

  initial begin
    #(64'd10_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    foreach (tail_bytes[i]) tail_bytes[i] = 8'd0;
  end

  function automatic int unsigned delim_span();
    return (delim_len_q > SPAN_MAX) ? SPAN_MAX : int'(delim_len_q);
  endfunction

  function automatic void drop_oldest();
    step_results.push_back('{tail_bytes[0], 1'b0, 32'd0, 1'b0, 1'b0});
    for (int i = 1; i < tail_fill; i++) tail_bytes[i-1] = tail_bytes[i];
    if (tail_fill > 0) begin
      tail_fill--;
      tail_bytes[tail_fill] = 8'd0;
    end
    if (open_length != '1) open_length++;
  endfunction

  function automatic void close_part(logic fin);
    step_results.push_back('{8'd0, 1'b1, open_length, fin, 1'b0});
    foreach (tail_bytes[i]) tail_bytes[i] = 8'd0;
    tail_fill = 0;
    open_length = '0;
  endfunction

  function automatic void predict_split(logic [7:0] b, logic has, logic eos);
    int unsigned span;
    bit hit;
    span = delim_span();
    step_results.delete();
    if (has) begin
      if (tail_fill < SPAN_MAX) begin
        tail_bytes[tail_fill] = b;
        tail_fill++;
      end
      if (tail_fill > span) begin
        drop_oldest();
      end else if (tail_fill == span && span > 0) begin
        hit = 1'b1;
        for (int i = 0; i < span; i++)
          if (tail_bytes[i] != delim_bytes_q[8*i +: 8]) hit = 1'b0;
        if (hit) close_part(1'b0);
        else drop_oldest();
      end
    end
    if (eos) begin
      while (tail_fill > 0) drop_oldest();
      close_part(1'b1);
    end
    if (step_results.size() > 0) step_results[step_results.size()-1].run_last = 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] flavor_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h2C;
      3: return 8'h61;
      4: return 8'h62;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned span;
    span = delim_span();
    if (span > 0 && $urandom_range(0, 9) < 4)
      return delim_bytes_q[8*$urandom_range(0, span-1) +: 8];
    return flavor_byte();
  endfunction

  task automatic check_part();
    split_result_t want;
    if (expected_parts.size() == 0) begin
      $error("result with nothing expected: part_byte %0h is_part_end %0b",
             part_byte, is_part_end);
      fail_count++;
    end else begin
      want = expected_parts.pop_front();
      if (part_byte !== want.part_byte) begin
        $error("part_byte: expected %0h, got %0h", want.part_byte, part_byte);
        fail_count++;
      end
      if (is_part_end !== want.is_part_end) begin
        $error("is_part_end: expected %0b, got %0b", want.is_part_end, is_part_end);
        fail_count++;
      end
      if (part_length !== want.part_length) begin
        $error("part_length: expected %0d, got %0d", want.part_length, part_length);
        fail_count++;
      end
      if (is_final_part !== want.is_final_part) begin
        $error("is_final_part: expected %0b, got %0b", want.is_final_part, is_final_part);
        fail_count++;
      end
      if (run_last !== want.run_last) begin
        $error("run_last: expected %0b, got %0b", want.run_last, run_last);
        fail_count++;
      end
    end
  endtask

  // result side: check each transfer, stall at random or on request
  initial begin : sink
    int unsigned stall;
    stall = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (pop && !empty) check_part();
      if (choke_cycles > 0) begin
        stall = choke_cycles;
        choke_cycles = 0;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  task automatic wait_idle();
    push <= 1'b0;
    while (expected_parts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [63:0] data);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == dss_pkg::CFG_DELIM_LENGTH) delim_len_q = data[3:0];
    else delim_bytes_q = data;
  endtask

  task automatic send_item(logic [7:0] b, logic has, logic eos, bit typed_on = 1'b0,
                           split_result_t typed = '0);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push          <= 1'b1;
    source_byte   <= b;
    has_byte      <= has;
    end_of_source <= eos;
    do @(posedge clk); while (full);
    predict_split(b, has, eos);
    if (typed_on) expected_parts.push_back(typed);
    else foreach (step_results[i]) expected_parts.push_back(step_results[i]);
    if (has || eos) source_items++;
  endtask

  task automatic pick_setting();
    logic [63:0] pattern;
    logic [3:0]  span;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) span = 4'd0;
    else if (r < 16) span = 4'($urandom_range(9, 15));
    else if (r < 24) span = 4'd8;
    else span = 4'($urandom_range(1, 4));
    r = $urandom_range(0, 9);
    if (r == 0) pattern = '0;
    else if (r == 1) pattern = '1;
    else if (r == 2) pattern = {$urandom, $urandom};
    else for (int i = 0; i < 8; i++) pattern[8*i +: 8] = flavor_byte();
    case ($urandom_range(0, 3))
      0: write_reg(dss_pkg::CFG_DELIM_LENGTH, {60'd0, span});
      1: write_reg(dss_pkg::CFG_DELIM_BYTES, pattern);
      default: begin
        write_reg(dss_pkg::CFG_DELIM_BYTES, pattern);
        write_reg(dss_pkg::CFG_DELIM_LENGTH, {60'd0, span});
      end
    endcase
  endtask

  task automatic send_noise(int unsigned n);
    repeat (n)
      send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 6) == 0));
  endtask

  // parts of random content joined by the delimiter; some separators cut short
  task automatic send_source(int unsigned parts);
    int unsigned span;
    int unsigned n;
    int unsigned r;
    span = delim_span();
    for (int p = 0; p < parts; p++) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
      repeat (n) send_item(pick_byte(), 1'b1, 1'b0);
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      if (p + 1 < parts) begin
        n = span;
        if (span > 0 && $urandom_range(0, 6) == 0) n = $urandom_range(0, span - 1);
        for (int i = 0; i < n; i++) send_item(delim_bytes_q[8*i +: 8], 1'b1, 1'b0);
      end
    end
    r = $urandom_range(0, 99);
    if (r < 15) return;
    if (r < 55) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    else send_item(pick_byte(), 1'b1, 1'b1);
  endtask

  initial begin : stimulus
    stim_row_t   row;
    int unsigned phase;
    int unsigned target;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_SET_LENGTH: write_reg(dss_pkg::CFG_DELIM_LENGTH, row.value);
        ROW_SET_BYTES:  write_reg(dss_pkg::CFG_DELIM_BYTES, row.value);
        ROW_ITEM:       send_item(row.value[7:0], row.has, row.eos);
        default:        send_item(row.value[7:0], row.has, row.eos, 1'b1,
                                  '{row.t_byte, row.t_end, row.t_len, row.t_fin, 1'b1});
      endcase
    end
    target = source_items + 350;
    phase = 0;
    while (source_items < target) begin
      steady = ($urandom_range(0, 5) == 0);
      if (phase == 0 || $urandom_range(0, 4) != 0) pick_setting();
      else wait_idle();
      if (phase == 3) begin
        // hold the result side while the source keeps pushing
        steady = 1'b1;
        choke_cycles = 300;
        send_source(12);
      end else if ($urandom_range(0, 4) == 0) begin
        send_noise($urandom_range(5, 20));
      end else begin
        send_source($urandom_range(1, 5));
      end
      phase++;
    end
    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
